// ----- sv/nkro_pkg.sv -----
// ----------------------------------------------------------------------------
// nkro_pkg
// Shared types, constants and the character table of the NKRO report builder.
// ----------------------------------------------------------------------------
package nkro_pkg;

    // Key bitmap geometry.
    localparam int KEY_BYTES    = 17;
    localparam int KEY_BITS     = KEY_BYTES * 8;
    localparam int IDX_W        = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int REPORT_BITS  = 136;
    localparam int IMG_BITS     = (KEY_BITS > REPORT_BITS) ? KEY_BITS : REPORT_BITS;
    localparam int KEY_LIMIT_I  = (KEY_BITS < 'h88) ? KEY_BITS : 'h88;
    localparam logic [8:0] KEY_LIMIT = 9'(KEY_LIMIT_I);

    // Command codes.
    localparam logic [2:0] CMD_PRESS       = 3'd0;
    localparam logic [2:0] CMD_RELEASE     = 3'd1;
    localparam logic [2:0] CMD_RAW_PRESS   = 3'd2;
    localparam logic [2:0] CMD_RAW_RELEASE = 3'd3;
    localparam logic [2:0] CMD_RELEASE_ALL = 3'd4;
    localparam logic [2:0] CMD_TYPE        = 3'd5;

    // Code space boundaries.
    localparam logic [7:0] CODE_MOD_BASE   = 8'h80;
    localparam logic [7:0] CODE_KEY_BASE   = 8'h88;
    localparam logic [7:0] USAGE_MOD_FIRST = 8'hE0;
    localparam logic [7:0] USAGE_MOD_END   = 8'hE8;
    localparam logic [2:0] LEFT_SHIFT_BIT  = 3'd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SET,
        OP_CLR
    } bit_op_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] key_code;
    } key_item_t;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  modifier_bits;
        logic [63:0] keys_low;
        logic [63:0] keys_mid;
        logic [7:0]  keys_high;
        logic        last;
    } rpt_item_t;

    // Decoded work for one transaction: up to four reports, each step holding
    // the cumulative operation on one key bit and one modifier bit.
    typedef struct packed {
        logic              ok;
        logic              clr_all;
        logic [IDX_W-1:0]  idx;
        logic [2:0]        bit_pos;
        logic [2:0]        mod_pos;
        logic [1:0]        last_step;
        bit_op_t [3:0]     key_ops;
        bit_op_t [3:0]     mod_ops;
    } plan_t;

    // Write-back of one key byte, or a clear of the whole bitmap.
    typedef struct packed {
        logic              en;
        logic              clr_all;
        logic [IDX_W-1:0]  addr;
        logic [7:0]        data;
    } wr_event_t;

    // ASCII to HID usage; bit 7 marks a character that needs left shift.
    localparam logic [7:0] CHAR_MAP [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

    function automatic logic key_ok(logic [7:0] u);
        return (u != 8'd0) && ({1'b0, u} < KEY_LIMIT);
    endfunction

endpackage

// ----- sv/nkro_decode.sv -----
// ----------------------------------------------------------------------------
// nkro_decode
// Turns one key transaction into a plan of up to four report steps.
// ----------------------------------------------------------------------------
module nkro_decode
    import nkro_pkg::*;
(
    input  key_item_t key_item,
    input  logic      shift_key_reports,
    output plan_t     plan
);

    logic [7:0] k;
    logic [7:0] ext_u;
    logic [7:0] map_v;
    logic       code_ok;
    logic       code_mod;
    logic       code_shift;
    logic [7:0] code_u;
    logic [2:0] code_mpos;
    logic       raw_mod;
    logic       raw_ok;
    logic [7:0] raw_u;
    logic       p_two;
    logic       r_two;
    bit_op_t    p_key [2];
    bit_op_t    p_mod [2];
    bit_op_t    r_key [2];
    bit_op_t    r_mod [2];
    bit_op_t    c_key [2];
    bit_op_t    c_mod [2];

    // A release step that leaves a bit alone keeps what the press left there.
    function automatic bit_op_t compose(bit_op_t rel, bit_op_t pre);
        return (rel != OP_NONE) ? rel : pre;
    endfunction

    always_comb
    begin
        k          = key_item.key_code;
        ext_u      = k - CODE_KEY_BASE;
        map_v      = CHAR_MAP[k[6:0]];
        code_ok    = 1'b0;
        code_mod   = 1'b0;
        code_shift = 1'b0;
        code_u     = 8'd0;
        code_mpos  = k[2:0];
        if (k >= CODE_KEY_BASE)
        begin
            code_ok = key_ok(ext_u);
            code_u  = ext_u;
        end
        else if (k >= CODE_MOD_BASE)
        begin
            code_ok  = 1'b1;
            code_mod = 1'b1;
        end
        else
        begin
            code_u     = {1'b0, map_v[6:0]};
            code_ok    = (map_v != 8'd0) && key_ok(code_u);
            code_shift = map_v[7];
            code_mpos  = LEFT_SHIFT_BIT;
        end

        // Press steps.
        p_key = '{OP_NONE, OP_NONE};
        p_mod = '{OP_NONE, OP_NONE};
        p_two = 1'b0;
        if (code_mod)
        begin
            p_mod[0] = OP_SET;
        end
        else if (code_shift && shift_key_reports)
        begin
            p_mod[0] = OP_SET;
            p_mod[1] = OP_SET;
            p_key[1] = OP_SET;
            p_two    = 1'b1;
        end
        else if (code_shift)
        begin
            p_mod[0] = OP_SET;
            p_key[0] = OP_SET;
        end
        else
        begin
            p_key[0] = OP_SET;
        end

        // Release steps.
        r_key = '{OP_NONE, OP_NONE};
        r_mod = '{OP_NONE, OP_NONE};
        r_two = 1'b0;
        if (code_mod)
        begin
            r_mod[0] = OP_CLR;
        end
        else if (code_shift && shift_key_reports)
        begin
            r_key[0] = OP_CLR;
            r_key[1] = OP_CLR;
            r_mod[1] = OP_CLR;
            r_two    = 1'b1;
        end
        else if (code_shift)
        begin
            r_mod[0] = OP_CLR;
            r_key[0] = OP_CLR;
        end
        else
        begin
            r_key[0] = OP_CLR;
        end

        c_key[0] = compose(r_key[0], p_key[p_two]);
        c_key[1] = compose(r_key[1], p_key[p_two]);
        c_mod[0] = compose(r_mod[0], p_mod[p_two]);
        c_mod[1] = compose(r_mod[1], p_mod[p_two]);

        raw_mod = (k >= USAGE_MOD_FIRST) && (k < USAGE_MOD_END);
        raw_ok  = raw_mod || key_ok(k);
        raw_u   = raw_mod ? 8'd0 : k;

        plan           = '0;
        plan.ok        = code_ok;
        plan.idx       = IDX_W'(code_u >> 3);
        plan.bit_pos   = code_u[2:0];
        plan.mod_pos   = code_mpos;

        unique case (key_item.cmd) inside
            CMD_PRESS:
            begin
                plan.last_step  = {1'b0, p_two};
                plan.key_ops[0] = p_key[0];
                plan.key_ops[1] = p_key[1];
                plan.mod_ops[0] = p_mod[0];
                plan.mod_ops[1] = p_mod[1];
            end
            CMD_RELEASE:
            begin
                plan.last_step  = {1'b0, r_two};
                plan.key_ops[0] = r_key[0];
                plan.key_ops[1] = r_key[1];
                plan.mod_ops[0] = r_mod[0];
                plan.mod_ops[1] = r_mod[1];
            end
            CMD_TYPE:
            begin
                plan.last_step  = {1'b0, p_two} + {1'b0, r_two} + 2'd1;
                plan.key_ops[0] = p_key[0];
                plan.mod_ops[0] = p_mod[0];
                if (p_two)
                begin
                    plan.key_ops[1] = p_key[1];
                    plan.mod_ops[1] = p_mod[1];
                    plan.key_ops[2] = c_key[0];
                    plan.mod_ops[2] = c_mod[0];
                    plan.key_ops[3] = c_key[1];
                    plan.mod_ops[3] = c_mod[1];
                end
                else
                begin
                    plan.key_ops[1] = c_key[0];
                    plan.mod_ops[1] = c_mod[0];
                end
            end
            CMD_RAW_PRESS, CMD_RAW_RELEASE:
            begin
                plan.ok      = raw_ok;
                plan.idx     = IDX_W'(raw_u >> 3);
                plan.bit_pos = raw_u[2:0];
                plan.mod_pos = k[2:0];
                if (raw_mod)
                    plan.mod_ops[0] = (key_item.cmd == CMD_RAW_PRESS) ? OP_SET : OP_CLR;
                else
                    plan.key_ops[0] = (key_item.cmd == CMD_RAW_PRESS) ? OP_SET : OP_CLR;
            end
            CMD_RELEASE_ALL:
            begin
                plan.ok      = 1'b1;
                plan.clr_all = 1'b1;
                plan.idx     = '0;
            end
            default:
            begin
                plan.ok = 1'b0;
            end
        endcase

        // A rejected transaction changes nothing and gives a single result.
        if (!plan.ok)
        begin
            plan.idx       = '0;
            plan.last_step = 2'd0;
            plan.key_ops   = '{OP_NONE, OP_NONE, OP_NONE, OP_NONE};
            plan.mod_ops   = '{OP_NONE, OP_NONE, OP_NONE, OP_NONE};
        end
    end

endmodule

// ----- sv/nkro_key_ram.sv -----
// ----------------------------------------------------------------------------
// nkro_key_ram
// Key bitmap store: one byte per entry, registered read, per-entry valid bits
// so that reset and release-all clear the whole bitmap at once.
// ----------------------------------------------------------------------------
module nkro_key_ram
    import nkro_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  wr_event_t        wev,
    output logic [7:0]       rd_data
);

    logic [7:0]           mem [KEY_BYTES];
    logic [KEY_BYTES-1:0] valid_reg;
    logic [7:0]           rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wev.en)
            mem[wev.addr] <= wev.data;
        if (rd_en)
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wev.clr_all)
            valid_reg <= '0;
        else if (wev.en)
            valid_reg[wev.addr] <= 1'b1;
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/nkro_report.sv -----
// ----------------------------------------------------------------------------
// nkro_report
// Read-modify-write sequencer: holds the byte read for the next transaction,
// steps through the plan at one report per unstalled cycle and writes back.
// ----------------------------------------------------------------------------
module nkro_report
    import nkro_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_ready,
    input  plan_t     dec_plan,
    input  logic [7:0] rd_data,
    output wr_event_t wev,
    output logic      rpt_valid,
    input  logic      rpt_ready,
    output rpt_item_t rpt_item
);

    logic                a_valid_reg, a_valid_next;
    plan_t               a_plan_reg, a_plan_next;
    logic                a_fresh_reg, a_fresh_next;
    logic                a_fwd_hit_reg, a_fwd_hit_next;
    logic [7:0]          a_fwd_data_reg, a_fwd_data_next;
    logic [7:0]          a_byte_reg, a_byte_next;
    logic                b_valid_reg, b_valid_next;
    plan_t               b_plan_reg, b_plan_next;
    logic [7:0]          b_byte_reg, b_byte_next;
    logic [1:0]          b_step_reg, b_step_next;
    logic [7:0]          mod_reg, mod_next;
    logic [KEY_BITS-1:0] image_reg, image_next;
    logic                rpt_valid_reg, rpt_valid_next;
    rpt_item_t           rpt_item_reg, rpt_item_next;

    logic                key_accept;
    logic [7:0]          a_byte;
    logic [7:0]          a_byte_cur;
    logic                fire;
    logic                b_done;
    logic                a_move;
    bit_op_t             key_op;
    bit_op_t             mod_op;
    logic [7:0]          byte_s;
    logic [7:0]          mod_s;
    logic [KEY_BITS-1:0] image_s;
    logic [IMG_BITS-1:0] img_ext;
    rpt_item_t           report;

    function automatic logic [7:0] apply_op(logic [7:0] v, logic [2:0] pos, bit_op_t op);
        logic [7:0] mask;
        mask = 8'd1 << pos;
        case (op)
            OP_SET:  return v | mask;
            OP_CLR:  return v & ~mask;
            default: return v;
        endcase
    endfunction

    function automatic logic [7:0] forward(logic [7:0] v, logic [IDX_W-1:0] addr,
                                           wr_event_t ev);
        if (ev.clr_all)
            return 8'd0;
        else if (ev.en && (ev.addr == addr))
            return ev.data;
        else
            return v;
    endfunction

    always_comb
    begin
        key_accept = key_valid && key_ready;
        a_byte     = a_fresh_reg ? (a_fwd_hit_reg ? a_fwd_data_reg : rd_data) : a_byte_reg;
        a_byte_cur = forward(a_byte, a_plan_reg.idx, wev);

        fire   = b_valid_reg && (!rpt_valid_reg || rpt_ready);
        b_done = fire && (b_step_reg == b_plan_reg.last_step);
        a_move = a_valid_reg && (!b_valid_reg || b_done);

        key_op  = b_plan_reg.key_ops[b_step_reg];
        mod_op  = b_plan_reg.mod_ops[b_step_reg];
        byte_s  = apply_op(b_byte_reg, b_plan_reg.bit_pos, key_op);
        mod_s   = apply_op(mod_reg, b_plan_reg.mod_pos, mod_op);
        image_s = image_reg;
        image_s[{b_plan_reg.idx, 3'b000} +: 8] = byte_s;
        if (b_plan_reg.clr_all)
        begin
            byte_s  = 8'd0;
            mod_s   = 8'd0;
            image_s = '0;
        end
        img_ext = IMG_BITS'(image_s);

        report.accepted      = b_plan_reg.ok;
        report.modifier_bits = mod_s;
        report.keys_low      = img_ext[63:0];
        report.keys_mid      = img_ext[127:64];
        report.keys_high     = img_ext[135:128];
        report.last          = (b_step_reg == b_plan_reg.last_step);

        wev.en      = b_done && b_plan_reg.ok && !b_plan_reg.clr_all;
        wev.clr_all = b_done && b_plan_reg.clr_all;
        wev.addr    = b_plan_reg.idx;
        wev.data    = byte_s;

        key_ready = !a_valid_reg || a_move;

        a_valid_next    = key_accept ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
        a_plan_next     = key_accept ? dec_plan : a_plan_reg;
        a_fresh_next    = key_accept;
        a_fwd_hit_next  = wev.clr_all || (wev.en && (wev.addr == dec_plan.idx));
        a_fwd_data_next = wev.clr_all ? 8'd0 : wev.data;
        a_byte_next     = a_byte_cur;

        b_valid_next = a_move ? 1'b1 : (b_done ? 1'b0 : b_valid_reg);
        b_plan_next  = a_move ? a_plan_reg : b_plan_reg;
        b_byte_next  = a_move ? a_byte_cur : b_byte_reg;
        if (a_move)
            b_step_next = 2'd0;
        else if (fire)
            b_step_next = b_step_reg + 2'd1;
        else
            b_step_next = b_step_reg;

        mod_next   = (b_done && b_plan_reg.ok) ? mod_s : mod_reg;
        image_next = (b_done && b_plan_reg.ok) ? image_s : image_reg;

        rpt_valid_next = fire ? 1'b1 : (rpt_ready ? 1'b0 : rpt_valid_reg);
        rpt_item_next  = fire ? report : rpt_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            a_fresh_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            b_step_reg    <= 2'd0;
            mod_reg       <= 8'd0;
            image_reg     <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            a_fresh_reg   <= a_fresh_next;
            b_valid_reg   <= b_valid_next;
            b_step_reg    <= b_step_next;
            mod_reg       <= mod_next;
            image_reg     <= image_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_plan_reg     <= a_plan_next;
        a_fwd_hit_reg  <= a_fwd_hit_next;
        a_fwd_data_reg <= a_fwd_data_next;
        a_byte_reg     <= a_byte_next;
        b_plan_reg     <= b_plan_next;
        b_byte_reg     <= b_byte_next;
        rpt_item_reg   <= rpt_item_next;
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt_item  = rpt_item_reg;

endmodule

// ----- sv/nkro_key_report_builder.sv -----
// ----------------------------------------------------------------------------
// nkro_key_report_builder
// N-key-rollover keyboard state with full-report output per change.
// ----------------------------------------------------------------------------
// Each key transaction (press, release, raw press, raw release, release-all,
// type) produces one to four full reports: a plain key or modifier change gives
// one, a shifted character gives two when shift_key_reports is set, and type
// gives the press reports followed by the release reports. A transaction that
// cannot be mapped gives a single report with accepted low and the state
// unchanged. The key bitmap lives in a small synchronous memory; the block
// reads the touched byte when a transaction is accepted, holds it in a staging
// register (with forwarding from the write-back of the transaction ahead of
// it), then a sequencer emits one report per cycle unless the output stalls,
// and writes the byte back on the last one. A transaction moves from the
// staging register into the sequencer and holds it until its last report
// reaches the output register, so single-report transactions stream at one
// per cycle too. The output register lets the next transaction be accepted
// while a report waits to be taken. Reset and release-all clear the bitmap
// at once through per-byte valid bits, so no clearing pass is needed. The
// configuration register is written through its own channel, which is always
// ready, and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module nkro_key_report_builder
    import nkro_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_valid,
    output logic      key_ready,
    input  key_item_t key_item,
    output logic      rpt_valid,
    input  logic      rpt_ready,
    output rpt_item_t rpt_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic      shift_key_reports_reg, shift_key_reports_next;
    plan_t     dec_plan;
    wr_event_t wev;
    logic [7:0] rd_data;
    logic      key_accept;

    // The configuration channel never stalls.
    assign cfg_ready  = 1'b1;
    assign key_accept = key_valid && key_ready;

    always_comb
    begin
        shift_key_reports_next = (cfg_valid && cfg_ready) ? cfg_data : shift_key_reports_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_key_reports_reg <= 1'b1;
        else
            shift_key_reports_reg <= shift_key_reports_next;
    end

    // The plan is decoded from the incoming payload so that the byte read can
    // be issued in the same cycle as the transaction.
    nkro_decode u_decode (
        .key_item          (key_item),
        .shift_key_reports (shift_key_reports_reg),
        .plan              (dec_plan)
    );

    nkro_key_ram u_key_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (key_accept),
        .rd_addr (dec_plan.idx),
        .wev     (wev),
        .rd_data (rd_data)
    );

    nkro_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .dec_plan  (dec_plan),
        .rd_data   (rd_data),
        .wev       (wev),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt_item  (rpt_item)
    );

endmodule

// ----- verif/nkro_key_report_builder_tb.sv -----
// ----------------------------------------------------------------------------
// nkro_key_report_builder_tb
// Self-checking bench for the NKRO keyboard report builder. Key transactions
// are driven with random gaps, and reports are taken with random stalls. An
// independent model of the modifier byte and key bitmap predicts every
// report, and each report is compared field by field in arrival order.
// ----------------------------------------------------------------------------

// Tracks the keyboard state as the block should see it, queues the reports
// that each key transaction should produce and checks arriving reports.
class report_tracker;

    logic [7:0]   mods;
    logic [135:0] keymap;
    bit           shift_apart;
    nkro_pkg::rpt_item_t batch[$];
    nkro_pkg::rpt_item_t due_reports[$];
    int errors;
    int keys_seen;
    int reports_seen;
    int rejects_seen;

    // ASCII to HID usage. Bit 7 set means the character needs left shift.
    logic [7:0] ascii_usage [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

    function new();
        mods         = '0;
        keymap       = '0;
        shift_apart  = 1'b1;
        errors       = 0;
        keys_seen    = 0;
        reports_seen = 0;
        rejects_seen = 0;
    endfunction

    function void set_shift_apart(bit v);
        shift_apart = v;
    endfunction

    function int pending();
        return due_reports.size();
    endfunction

    // A key usage must lie inside both the bitmap and the report.
    function bit usage_ok(int u);
        int key_end;
        key_end = (nkro_pkg::KEY_BYTES * 8 < 'h88) ? nkro_pkg::KEY_BYTES * 8 : 'h88;
        return (u >= 1) && (u < key_end);
    endfunction

    function void set_key(int u, bit on);
        if (u < nkro_pkg::KEY_BYTES * 8 && u < 136)
            keymap[u] = on;
    endfunction

    function void snap(bit acc);
        nkro_pkg::rpt_item_t r;
        r.accepted      = acc;
        r.modifier_bits = mods;
        r.keys_low      = keymap[63:0];
        r.keys_mid      = keymap[127:64];
        r.keys_high     = keymap[135:128];
        r.last          = 1'b0;
        batch.push_back(r);
    endfunction

    function void press(int k);
        int m;
        int u;
        if (k >= 'h88)
        begin
            u = k - 'h88;
            if (!usage_ok(u))
                return;
            set_key(u, 1'b1);
            snap(1'b1);
        end
        else if (k >= 'h80)
        begin
            mods[k - 'h80] = 1'b1;
            snap(1'b1);
        end
        else
        begin
            m = int'(ascii_usage[k]);
            u = m & 'h7F;
            if (m == 0 || !usage_ok(u))
                return;
            if ((m & 'h80) != 0)
            begin
                mods[1] = 1'b1;
                if (shift_apart)
                    snap(1'b1);
            end
            set_key(u, 1'b1);
            snap(1'b1);
        end
    endfunction

    function void release_key(int k);
        int m;
        int u;
        if (k >= 'h88)
        begin
            u = k - 'h88;
            if (!usage_ok(u))
                return;
            set_key(u, 1'b0);
            snap(1'b1);
        end
        else if (k >= 'h80)
        begin
            mods[k - 'h80] = 1'b0;
            snap(1'b1);
        end
        else
        begin
            m = int'(ascii_usage[k]);
            u = m & 'h7F;
            if (m == 0 || !usage_ok(u))
                return;
            // With separate shift reports the key goes up first, then shift.
            if ((m & 'h80) != 0 && shift_apart)
            begin
                set_key(u, 1'b0);
                snap(1'b1);
                mods[1] = 1'b0;
                snap(1'b1);
                return;
            end
            if ((m & 'h80) != 0)
                mods[1] = 1'b0;
            set_key(u, 1'b0);
            snap(1'b1);
        end
    endfunction

    function void raw_key(int k, bit on);
        if (k >= 'hE0 && k < 'hE8)
            mods[k - 'hE0] = on;
        else if (usage_ok(k))
            set_key(k, on);
        else
            return;
        snap(1'b1);
    endfunction

    // Called for every accepted key transaction.
    function void note_key(nkro_pkg::key_item_t item);
        int k;
        k = int'(item.key_code);
        batch.delete();
        keys_seen++;
        case (item.cmd)
            nkro_pkg::CMD_PRESS:       press(k);
            nkro_pkg::CMD_RELEASE:     release_key(k);
            nkro_pkg::CMD_RAW_PRESS:   raw_key(k, 1'b1);
            nkro_pkg::CMD_RAW_RELEASE: raw_key(k, 1'b0);
            nkro_pkg::CMD_RELEASE_ALL:
            begin
                keymap = '0;
                mods   = '0;
                snap(1'b1);
            end
            nkro_pkg::CMD_TYPE:
            begin
                press(k);
                if (batch.size() > 0)
                    release_key(k);
            end
            default: ;
        endcase
        if (batch.size() == 0)
        begin
            snap(1'b0);
            rejects_seen++;
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            due_reports.push_back(batch[i]);
    endfunction

    function void field_diff(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
            errors++;
        end
    endfunction

    // Called for every report the block hands over.
    function void check_report(nkro_pkg::rpt_item_t got);
        nkro_pkg::rpt_item_t want;
        if (due_reports.size() == 0)
        begin
            $display("%0t: report with no transaction pending, expected none, got %h",
                     $time, got);
            errors++;
            return;
        end
        want = due_reports.pop_front();
        reports_seen++;
        field_diff("accepted", 64'(want.accepted), 64'(got.accepted));
        field_diff("modifier_bits", 64'(want.modifier_bits), 64'(got.modifier_bits));
        field_diff("keys_low", want.keys_low, got.keys_low);
        field_diff("keys_mid", want.keys_mid, got.keys_mid);
        field_diff("keys_high", 64'(want.keys_high), 64'(got.keys_high));
        field_diff("last", 64'(want.last), 64'(got.last));
    endfunction

endclass

module nkro_key_report_builder_tb
    import nkro_pkg::*;
();

    // Command values the block does not define; both must be rejected.
    localparam logic [2:0] CMD_BAD_FIRST = 3'd6;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;

    // Watchdog limit in clock cycles. The slowest correct run is far below
    // this: about 470 transactions of at most four reports each, with random
    // gaps on the sending side and random stalls on the receiving side.
    localparam int CYCLE_LIMIT = 200000;

    // Items per random phase; four phases and the directed part give about
    // 470 transactions.
    localparam int PHASE_ITEMS = 111;

    // Cycles to let pass after the last report before touching the register.
    localparam int SETTLE_CYCLES = 8;

    logic      clk;
    logic      rst_n;
    logic      key_valid;
    logic      key_ready;
    key_item_t key_item;
    logic      rpt_valid;
    logic      rpt_ready;
    rpt_item_t rpt_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    report_tracker sb;
    bit            no_idle;
    int            cycle_count;

    // Keys currently held down, so that most releases match an earlier press.
    key_item_t held[$];

    nkro_key_report_builder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_item  (key_item),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt_item  (rpt_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog counts cycles and ends a run that hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d reports still due", $time, sb.pending());
        $display("nkro_key_report_builder_tb failed");
        $finish;
    end

    // The receiving side stalls in about 29 percent of cycles, except during
    // the stretch in which idling is switched off.
    always @(negedge clk)
    begin
        rpt_ready <= no_idle || ($urandom_range(99) >= 29);
    end

    // Every report transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rpt_valid && rpt_ready)
            sb.check_report(rpt_item);
    end

    // Sends one key transaction. It starts and ends at a falling edge. Valid
    // is only dropped when a gap is inserted, so back-to-back transactions
    // keep it high without a glitch.
    task automatic send_key(input logic [2:0] op, input logic [7:0] code);
        if (!no_idle && $urandom_range(99) < 29)
        begin
            key_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 29);
        end
        key_item  <= {op, code};
        key_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (key_ready)
                break;
        end
        sb.note_key(key_item);
        @(negedge clk);
    endtask

    // Drains the block before a register write. Every transaction yields at
    // least one report, but spare cycles after the last one cover the pipeline anyway.
    task automatic settle();
        key_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_shift_mode(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.set_shift_apart(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range('h7E, 'h20));
    endfunction

    // Builds one random transaction. Most are presses of printable characters
    // or valid usages and releases of keys that are held; the rest is noise
    // over the whole code space, release-all and undefined commands.
    task automatic send_random();
        int        pick;
        int        idx;
        key_item_t it;
        pick = $urandom_range(99);
        if (pick < 34 && pick >= 22 && held.size() > 0)
        begin
            idx = $urandom_range(held.size() - 1);
            it  = held[idx];
            held.delete(idx);
            it.cmd = (it.cmd == CMD_PRESS) ? CMD_RELEASE : CMD_RAW_RELEASE;
        end
        else if (pick < 34)
        begin
            it.cmd      = CMD_PRESS;
            it.key_code = ($urandom_range(7) == 0) ? 8'($urandom_range('h7F)) : printable();
        end
        else if (pick < 50)
        begin
            it.cmd      = CMD_TYPE;
            it.key_code = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : printable();
        end
        else if (pick < 64)
        begin
            it.cmd = CMD_RAW_PRESS;
            case ($urandom_range(3))
                0:       it.key_code = 8'($urandom_range('hE7, 'hE0));
                1:       it.key_code = 8'($urandom_range(255));
                default: it.key_code = 8'($urandom_range('h87, 1));
            endcase
        end
        else if (pick < 80)
        begin
            // Modifiers and extended usages through the character path.
            it.cmd      = CMD_PRESS;
            it.key_code = 8'($urandom_range(255, 'h80));
        end
        else if (pick < 88)
        begin
            it.cmd      = CMD_RELEASE;
            it.key_code = 8'($urandom_range(255));
        end
        else if (pick < 94)
        begin
            it.cmd      = CMD_RAW_RELEASE;
            it.key_code = 8'($urandom_range(255));
        end
        else if (pick < 97)
        begin
            it.cmd      = CMD_RELEASE_ALL;
            it.key_code = 8'($urandom_range(255));
            held.delete();
        end
        else
        begin
            it.cmd      = 3'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST));
            it.key_code = 8'($urandom_range(255));
        end
        if ((it.cmd == CMD_PRESS || it.cmd == CMD_RAW_PRESS) && held.size() < 12)
            held.push_back(it);
        send_key(it.cmd, it.key_code);
    endtask

    initial
    begin
        sb        = new();
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        key_valid = 1'b0;
        key_item  = '0;
        rpt_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with shift sent as its own report (the reset mode).
        // A shifted capital goes out as two reports on press and on release,
        // and typing it gives all four.
        send_key(CMD_PRESS, 8'h41);
        send_key(CMD_RELEASE, 8'h41);
        send_key(CMD_TYPE, 8'h41);
        send_key(CMD_TYPE, 8'h61);
        // Modifier bits through the character path, lowest and highest.
        send_key(CMD_PRESS, 8'h80);
        send_key(CMD_RELEASE, 8'h80);
        send_key(CMD_PRESS, 8'h87);
        // The first extended code maps to usage zero and is rejected; the
        // last one is a valid key.
        send_key(CMD_PRESS, 8'h88);
        send_key(CMD_PRESS, 8'hFF);
        send_key(CMD_RELEASE, 8'hFF);
        // Unmapped characters, and a type that is rejected as a whole.
        send_key(CMD_PRESS, 8'h00);
        send_key(CMD_PRESS, 8'h7F);
        send_key(CMD_TYPE, 8'h00);
        // Raw usages at both ends of the key range, just outside it, and the
        // modifier usages.
        send_key(CMD_RAW_PRESS, 8'h01);
        send_key(CMD_RAW_PRESS, 8'h87);
        send_key(CMD_RAW_PRESS, 8'h88);
        send_key(CMD_RAW_PRESS, 8'h00);
        send_key(CMD_RAW_PRESS, 8'hE0);
        send_key(CMD_RAW_PRESS, 8'hE7);
        send_key(CMD_RAW_PRESS, 8'hE8);
        send_key(CMD_RAW_RELEASE, 8'hFF);
        send_key(CMD_RAW_RELEASE, 8'h87);
        send_key(CMD_RELEASE_ALL, 8'h00);
        // Undefined commands are rejected whatever the key code.
        send_key(CMD_BAD_FIRST, 8'hFF);
        send_key(CMD_BAD_LAST, 8'h00);

        // With shift folded into the key report, each edge gives one report.
        settle();
        write_shift_mode(1'b0);
        send_key(CMD_PRESS, 8'h41);
        send_key(CMD_RELEASE, 8'h41);
        send_key(CMD_TYPE, 8'h7E);

        // Random phases alternate the shift mode. The second phase runs with
        // no gaps and no stalls on either side.
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            write_shift_mode(phase % 2 == 0);
            no_idle = (phase == 1);
            repeat (PHASE_ITEMS) send_random();
        end
        no_idle = 1'b0;
        key_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Drove %0d key transactions (%0d rejected) and checked %0d reports,",
                 sb.keys_seen, sb.rejects_seen, sb.reports_seen);
        $display("with shift reported both on its own and together with the key.");
        if (sb.errors == 0)
            $display("nkro_key_report_builder_tb passed");
        else
            $display("nkro_key_report_builder_tb failed");
        $finish;
    end

endmodule
